/* hw/rtl/lts_pkg.sv */
// Shared types and constants for the LRU tag store.
// Used by the controller, the datapath, the top level and the checker; depends on nothing.
`default_nettype none

package lts_pkg;

  // Fixed field widths of the request and result ports.
  localparam int KEY_PORT_W = 64;
  localparam int OBJ_W      = 20;
  localparam int SIZE_W     = 17;
  localparam int STAMP_W    = 32;
  localparam int WAY_OUT_W  = 4;

  // Request command codes.
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_FILL   = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request and rewind the scan index
    logic issue;    // read the entry at the scan index and advance
    logic commit;   // write back the entry and load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // the scan index points at the last way
  } dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/lts_ctrl.sv */
// Controller state machine of the LRU tag store.
// Depends on lts_pkg; drives the datapath through ctrl_cmd_t.
`default_nettype none

module lts_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               request_valid,
  output logic              request_stall,
  output logic              result_valid,
  input  wire               result_stall,
  input  lts_pkg::dp_status_t status,
  output lts_pkg::ctrl_cmd_t  cmd
);
  import lts_pkg::*;

  state_t state;
  state_t state_next;
  logic   result_free;

  // The result register can take a new result when it is empty or being drained.
  assign result_free = !result_valid || !result_stall;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    request_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        request_stall = 1'b0;
        if (request_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (result_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Result valid flag: set on commit, cleared when the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lts_datapath.sv */
// Datapath of the LRU tag store: entry memories, valid bits, scan unit,
// use counter and result register. Depends on lts_pkg.
`default_nettype none

module lts_datapath #(
  parameter int WAYS       = 10,
  parameter int MAX_OBJECT = 102400,
  parameter int KEY_BITS   = 64
) (
  input  wire                               clk,
  input  wire                               rst,
  input  lts_pkg::ctrl_cmd_t                cmd,
  output lts_pkg::dp_status_t               status,
  input  wire                               command,
  input  wire [lts_pkg::KEY_PORT_W-1:0]     key_tag,
  input  wire [lts_pkg::OBJ_W-1:0]          object_size,
  output logic                              hit,
  output logic [lts_pkg::WAY_OUT_W-1:0]     way,
  output logic [lts_pkg::SIZE_W-1:0]        found_size,
  output logic                              stored
);
  import lts_pkg::*;

  localparam int IDX_W = $clog2(WAYS);

  // Latched request.
  logic                req_cmd;
  logic [KEY_BITS-1:0] req_key;
  logic [OBJ_W-1:0]    req_size;

  // Entry memories and valid bits.
  logic [KEY_BITS-1:0] key_mem   [WAYS];
  logic [SIZE_W-1:0]   size_mem  [WAYS];
  logic [STAMP_W-1:0]  stamp_mem [WAYS];
  logic [WAYS-1:0]     valid;

  // Scan read port.
  logic [IDX_W-1:0]    scan_idx;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_valid;
  logic                eval_en;
  logic [KEY_BITS-1:0] key_rd;
  logic [SIZE_W-1:0]   size_rd;
  logic [STAMP_W-1:0]  stamp_rd;

  // Scan results.
  logic                hit_found;
  logic [IDX_W-1:0]    hit_way;
  logic [SIZE_W-1:0]   hit_size;
  logic                found_empty;
  logic [IDX_W-1:0]    victim_way;
  logic [STAMP_W-1:0]  victim_stamp;

  logic [STAMP_W-1:0]  use_counter;

  // Combinational helpers.
  logic [SIZE_W-1:0]   size_eff;
  logic [STAMP_W-1:0]  stamp_eff;
  logic                first_way;
  logic                key_match;
  logic                way_empty;
  logic                size_ok;
  logic                do_fill;
  logic                do_touch;
  logic [IDX_W-1:0]    wr_way;
  logic [STAMP_W-1:0]  stamp_new;
  logic [IDX_W+WAY_OUT_W-1:0] result_way_ext;

  assign status.scan_last = (scan_idx == IDX_W'(WAYS - 1));

  // A never-written entry reads as empty with a zero stamp.
  assign size_eff  = rd_valid ? size_rd : '0;
  assign stamp_eff = rd_valid ? stamp_rd : '0;
  assign first_way = (rd_idx == '0);
  assign key_match = rd_valid && (key_rd == req_key);
  assign way_empty = (size_eff == '0);

  // Write-back decision.
  assign size_ok   = (req_size < OBJ_W'(MAX_OBJECT));
  assign do_fill   = (req_cmd == CMD_FILL) && size_ok;
  assign do_touch  = (req_cmd == CMD_LOOKUP) && hit_found;
  assign wr_way    = (req_cmd == CMD_FILL) ? victim_way : hit_way;
  assign stamp_new = use_counter + 1'b1;

  // Reported way is the entry index kept modulo sixteen, or zero on a lookup miss.
  always_comb begin
    if (req_cmd == CMD_FILL) begin
      result_way_ext = {{WAY_OUT_W{1'b0}}, victim_way};
    end else if (hit_found) begin
      result_way_ext = {{WAY_OUT_W{1'b0}}, hit_way};
    end else begin
      result_way_ext = '0;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_cmd  <= command;
      req_key  <= key_tag[KEY_BITS-1:0];
      req_size <= object_size;
    end
  end

  // Scan index walks the ways one per cycle.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      scan_idx <= '0;
    end else if (cmd.issue) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  // Evaluation strobe is the issue command registered, so it follows each read in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      eval_en <= 1'b0;
    end else begin
      eval_en <= cmd.issue;
    end
  end

  // Entry memories: one write port for commit, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (cmd.commit && do_fill) begin
      key_mem[wr_way]  <= req_key;
      size_mem[wr_way] <= req_size[SIZE_W-1:0];
    end
    if (cmd.commit && (do_fill || do_touch)) begin
      stamp_mem[wr_way] <= stamp_new;
    end
    if (cmd.issue) begin
      key_rd   <= key_mem[scan_idx];
      size_rd  <= size_mem[scan_idx];
      stamp_rd <= stamp_mem[scan_idx];
      rd_idx   <= scan_idx;
      rd_valid <= valid[scan_idx];
    end
  end

  // Valid bits are set by the first fill that writes an entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.commit && do_fill) begin
      valid[wr_way] <= 1'b1;
    end
  end

  // Global use counter advances on every hit and every stored fill.
  always_ff @(posedge clk) begin
    if (rst) begin
      use_counter <= '0;
    end else if (cmd.commit && (do_fill || do_touch)) begin
      use_counter <= stamp_new;
    end
  end

  // Per-entry evaluation: lowest matching way, and victim as the first
  // empty way or else the lowest stamp with ties to the lowest way.
  always_ff @(posedge clk) begin
    if (eval_en) begin
      if (first_way) begin
        hit_found    <= key_match;
        hit_way      <= rd_idx;
        hit_size     <= size_eff;
        found_empty  <= way_empty;
        victim_way   <= rd_idx;
        victim_stamp <= stamp_eff;
      end else begin
        if (!hit_found && key_match) begin
          hit_found <= 1'b1;
          hit_way   <= rd_idx;
          hit_size  <= size_eff;
        end
        if (!found_empty) begin
          if (way_empty) begin
            found_empty <= 1'b1;
            victim_way  <= rd_idx;
          end else if (stamp_eff < victim_stamp) begin
            victim_way   <= rd_idx;
            victim_stamp <= stamp_eff;
          end
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit        <= do_touch;
      way        <= result_way_ext[WAY_OUT_W-1:0];
      found_size <= do_touch ? hit_size : '0;
      stored     <= do_fill;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lru_tag_store.sv */
// Top level of the LRU tag store: a fully associative tag store with
// timestamp replacement. Depends on lts_pkg, lts_ctrl and lts_datapath.
//
//   Channel   Handshake                      Payload
//   request   request_valid / request_stall  command, key_tag, object_size
//   result    result_valid / result_stall    hit, way, found_size, stored
//
// A request is taken in the idle state. The scan state then walks the entry memory
// through its single read port, the drain state evaluates the last entry and the
// commit state writes back and registers the result. A new request is taken while
// the previous result still waits; a stalled result holds the next write-back.
// Reset is synchronous and clears the valid bits, the use counter and the control state.
`default_nettype none

module lru_tag_store #(
  parameter int WAYS       = 10,
  parameter int MAX_OBJECT = 102400,
  parameter int KEY_BITS   = 64
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            request_valid,
  output logic                           request_stall,
  input  wire                            command,
  input  wire [lts_pkg::KEY_PORT_W-1:0]  key_tag,
  input  wire [lts_pkg::OBJ_W-1:0]       object_size,
  output logic                           result_valid,
  input  wire                            result_stall,
  output logic                           hit,
  output logic [lts_pkg::WAY_OUT_W-1:0]  way,
  output logic [lts_pkg::SIZE_W-1:0]     found_size,
  output logic                           stored
);
  import lts_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  lts_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .cmd           (cmd)
  );

  // Entry storage and scan.
  lts_datapath #(
    .WAYS       (WAYS),
    .MAX_OBJECT (MAX_OBJECT),
    .KEY_BITS   (KEY_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .command     (command),
    .key_tag     (key_tag),
    .object_size (object_size),
    .hit         (hit),
    .way         (way),
    .found_size  (found_size),
    .stored      (stored)
  );

endmodule

`default_nettype wire

/* hw/rtl/lts_checker.sv */
// Port-level checks for the LRU tag store, bound to the top level.
// Depends on lts_pkg and lru_tag_store.
`default_nettype none

module lts_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            request_valid,
  input wire                            request_stall,
  input wire                            result_valid,
  input wire                            result_stall,
  input wire                            hit,
  input wire [lts_pkg::WAY_OUT_W-1:0]   way,
  input wire [lts_pkg::SIZE_W-1:0]      found_size,
  input wire                            stored
);
  import lts_pkg::*;

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(hit) && $stable(way)
      && $stable(found_size) && $stable(stored))
    else $error("stalled result changed");

  // A result never reports both a lookup hit and a stored fill.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(hit && stored))
    else $error("result reports both hit and stored");

  // Only a hit carries a stored size.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !hit |-> found_size == '0)
    else $error("size reported without a hit");

  // The block works on one request at a time.
  assert property (@(posedge clk) disable iff (rst)
    request_valid && !request_stall |=> request_stall)
    else $error("second request taken while busy");

  // No result is presented right after reset.
  assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind lru_tag_store lts_checker u_lts_checker (.*);

`default_nettype wire
